// ----- hw/rtl/modular_exponentiation_macros.svh -----
// Assertion macros shared by the modular exponentiation RTL.
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MX_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/modexp_pkg.sv -----
// Shared constants and types for the modular exponentiation block.
`default_nettype none

package modexp_pkg;

    localparam int REG_W  = 32;
    localparam int ADDR_W = 3;

    localparam logic [ADDR_W-1:0] ADDR_EXPONENT = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_MODULUS  = 3'd4;

    localparam logic [REG_W-1:0] EXPONENT_RESET = 32'd0;
    localparam logic [REG_W-1:0] MODULUS_RESET  = 32'd1;

    typedef struct packed {
        logic busy;
        logic done;
    } eng_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/modexp_step.sv -----
// Shared modular step unit: (2*p + addend) mod m for a sum below 3*m.
`default_nettype none

module modexp_step #(
    parameter int WIDTH = 32
) (
    input  wire logic [WIDTH-1:0] p,
    input  wire logic [WIDTH-1:0] addend,
    input  wire logic [WIDTH-1:0] modv,
    output logic      [WIDTH-1:0] result
);

    logic [WIDTH+1:0] sum;
    logic [WIDTH+1:0] m1;
    logic [WIDTH+1:0] m2;
    logic [WIDTH+1:0] red;

    always_comb begin
        sum = {1'b0, p, 1'b0} + {2'b00, addend};
        m1  = {2'b00, modv};
        m2  = {1'b0, modv, 1'b0};
        if (sum >= m2) begin
            red = sum - m2;
        end else if (sum >= m1) begin
            red = sum - m1;
        end else begin
            red = sum;
        end
        result = red[WIDTH-1:0];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/modexp_core.sv -----
// Sequencer for base reduction and right-to-left square-and-multiply.
`default_nettype none

module modexp_core
    import modexp_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic             ack,
    input  wire logic [REG_W-1:0] base_in,
    input  wire logic [REG_W-1:0] exp_in,
    input  wire logic [REG_W-1:0] mod_in,
    output eng_status_t           status,
    output logic      [REG_W-1:0] result,
    output logic                  zero_mod
);

    localparam int CNT_W = $clog2(WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RED  = 3'd1;
    localparam logic [2:0] ST_TEST = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_SQ   = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] m_reg, m_next;
    logic [WIDTH-1:0] e_reg, e_next;
    logic [WIDTH-1:0] base_reg, base_next;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] p_reg, p_next;
    logic [WIDTH-1:0] b_reg, b_next;
    logic             zm_reg, zm_next;

    logic [63:0]      base_ext, exp_ext, mod_ext, acc_ext;
    logic [WIDTH-1:0] step_add, step_res;

    modexp_step #(.WIDTH(WIDTH)) u_step (
        .p      (p_reg),
        .addend (step_add),
        .modv   (m_reg),
        .result (step_res)
    );

    assign base_ext = 64'(base_in);
    assign exp_ext  = 64'(exp_in);
    assign mod_ext  = 64'(mod_in);
    assign acc_ext  = 64'(acc_reg);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        m_next     = m_reg;
        e_next     = e_reg;
        base_next  = base_reg;
        acc_next   = acc_reg;
        p_next     = p_reg;
        b_next     = b_reg;
        zm_next    = zm_reg;
        step_add   = '0;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    m_next   = mod_ext[WIDTH-1:0];
                    e_next   = exp_ext[WIDTH-1:0];
                    b_next   = base_ext[WIDTH-1:0];
                    p_next   = '0;
                    acc_next = WIDTH'(1);
                    cnt_next = CNT_LAST;
                    if (mod_ext[WIDTH-1:0] == '0) begin
                        acc_next   = '0;
                        zm_next    = 1'b1;
                        state_next = ST_FIN;
                    end else begin
                        zm_next    = 1'b0;
                        state_next = ST_RED;
                    end
                end
            end
            ST_RED: begin
                step_add = {{(WIDTH-1){1'b0}}, b_reg[WIDTH-1]};
                p_next   = step_res;
                b_next   = b_reg << 1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    base_next  = step_res;
                    state_next = ST_TEST;
                end
            end
            ST_TEST: begin
                p_next   = '0;
                cnt_next = CNT_LAST;
                if (e_reg == '0) begin
                    state_next = ST_FIN;
                end else if (e_reg[0]) begin
                    b_next     = acc_reg;
                    state_next = ST_MUL;
                end else begin
                    b_next     = base_reg;
                    state_next = ST_SQ;
                end
            end
            ST_MUL: begin
                step_add = b_reg[WIDTH-1] ? base_reg : '0;
                p_next   = step_res;
                b_next   = b_reg << 1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    acc_next = step_res;
                    p_next   = '0;
                    cnt_next = CNT_LAST;
                    if (e_reg[WIDTH-1:1] == '0) begin
                        e_next     = '0;
                        state_next = ST_TEST;
                    end else begin
                        b_next     = base_reg;
                        state_next = ST_SQ;
                    end
                end
            end
            ST_SQ: begin
                step_add = b_reg[WIDTH-1] ? base_reg : '0;
                p_next   = step_res;
                b_next   = b_reg << 1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    base_next  = step_res;
                    e_next     = e_reg >> 1;
                    state_next = ST_TEST;
                end
            end
            ST_FIN: begin
                if (ack) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        cnt_reg  <= cnt_next;
        m_reg    <= m_next;
        e_reg    <= e_next;
        base_reg <= base_next;
        acc_reg  <= acc_next;
        p_reg    <= p_next;
        b_reg    <= b_next;
        zm_reg   <= zm_next;
    end

    assign status.busy = (state_reg != ST_IDLE);
    assign status.done = (state_reg == ST_FIN);
    assign result      = acc_ext[REG_W-1:0];
    assign zero_mod    = zm_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/modular_exponentiation.sv -----
// A zero modulus gives a zero result with zero_modulus set; else the base is reduced mod m,
// then each exponent bit, lowest first, multiplies into the result if set and squares the base.
// The shared step unit handles one operand bit a cycle; no input beat is taken while busy.
// A finished beat waits in the output register while the next input beat is taken.
// Reset (aresetn low, synchronous): exponent 0, modulus 1, engine idle, output empty.
`default_nettype none

`include "modular_exponentiation_macros.svh"

module modular_exponentiation
    import modexp_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [REG_W-1:0]  pwdata,
    output logic      [REG_W-1:0]  prdata,
    output logic                   pready,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [REG_W-1:0]  s_tdata,   // [31:0] cipher_value
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [REG_W-1:0]  m_tdata,   // [31:0] plain_value
    output logic      [0:0]        m_tuser    // [0] zero_modulus
);

    logic [REG_W-1:0] exponent_reg, exponent_next;
    logic [REG_W-1:0] modulus_reg, modulus_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [REG_W-1:0] m_tdata_reg;
    logic             m_tuser_reg;

    eng_status_t      status;
    logic [REG_W-1:0] core_result;
    logic             core_zero_mod;
    logic             cfg_write;
    logic             in_beat;
    logic             out_load;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign s_tready  = !status.busy;
    assign in_beat   = s_tvalid && s_tready;
    assign out_load  = status.done && (!m_tvalid_reg || m_tready);

    always_comb begin
        exponent_next = exponent_reg;
        modulus_next  = modulus_reg;
        if (cfg_write) begin
            case (paddr)
                ADDR_EXPONENT: exponent_next = pwdata;
                ADDR_MODULUS:  modulus_next  = pwdata;
                default:       ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            ADDR_EXPONENT: prdata = exponent_reg;
            ADDR_MODULUS:  prdata = modulus_reg;
            default:       prdata = '0;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    modexp_core #(.WIDTH(WIDTH)) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (in_beat),
        .ack      (out_load),
        .base_in  (s_tdata),
        .exp_in   (exponent_reg),
        .mod_in   (modulus_reg),
        .status   (status),
        .result   (core_result),
        .zero_mod (core_zero_mod)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exponent_reg <= EXPONENT_RESET;
            modulus_reg  <= MODULUS_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            exponent_reg <= exponent_next;
            modulus_reg  <= modulus_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        if (out_load) begin
            m_tdata_reg <= core_result;
            m_tuser_reg <= core_zero_mod;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    `MX_ASSERT_NOW(a_zero_mod_data, m_tvalid && m_tuser[0], m_tdata == '0, "zero modulus data")
    `MX_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")
    `MX_ASSERT_NEXT(a_done_held, status.done && m_tvalid && !m_tready, status.done, "done lost")

endmodule

`default_nettype wire
